@@ hw/rtl/u8sd_pkg.sv @@
// u8sd_pkg: shared types and constants for the UTF-8 stream decoder.
// No dependencies.
package u8sd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CpW     = 21;
  localparam int unsigned PendW   = 2;
  localparam int unsigned PayW    = 6;

  // Lead and continuation byte masks and patterns
  localparam logic [ByteW-1:0] ContMask  = 8'hC0;
  localparam logic [ByteW-1:0] ContPat   = 8'h80;
  localparam logic [ByteW-1:0] Lead2Mask = 8'hE0;
  localparam logic [ByteW-1:0] Lead2Pat  = 8'hC0;
  localparam logic [ByteW-1:0] Lead3Mask = 8'hF0;
  localparam logic [ByteW-1:0] Lead3Pat  = 8'hE0;
  localparam logic [ByteW-1:0] Lead4Mask = 8'hF8;
  localparam logic [ByteW-1:0] Lead4Pat  = 8'hF0;
  localparam logic [ByteW-1:0] PayMask   = 8'h3F;

  // Decoder state carried between items
  typedef struct packed {
    logic [PendW-1:0] pending;
    logic [CpW-1:0]   partial;
  } u8sd_state_t;

  // Outcome of decoding one item
  typedef struct packed {
    logic           emit;
    logic [CpW-1:0] code_point;
  } u8sd_result_t;

endpackage

@@ hw/rtl/u8sd_step.sv @@
// u8sd_step: combinational decode of one byte against the current state.
// Depends on u8sd_pkg.
module u8sd_step import u8sd_pkg::*; (
  input  logic [ByteW-1:0] byte_i,
  input  logic             eos_i,
  input  u8sd_state_t      state_i,
  output u8sd_state_t      state_o,
  output u8sd_result_t     result_o
);

  logic             is_cont;
  logic [CpW-1:0]   shifted;
  logic [PendW-1:0] pend_dec;

  assign is_cont  = (byte_i & ContMask) == ContPat;
  assign shifted  = {state_i.partial[CpW-PayW-1:0], byte_i[PayW-1:0]};
  assign pend_dec = state_i.pending - PendW'(1);

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    if ((state_i.pending != '0) && is_cont) begin
      // continuation: shift in six payload bits
      if (pend_dec == '0) begin
        result_o.emit       = 1'b1;
        result_o.code_point = shifted;
        state_o             = '0;
      end else begin
        state_o.pending = pend_dec;
        state_o.partial = shifted;
      end
    end else begin
      // lead byte; any open sequence is dropped (partial is zero when idle)
      state_o = '0;
      if (!byte_i[ByteW-1]) begin
        result_o.emit       = 1'b1;
        result_o.code_point = CpW'(byte_i);
      end else if ((byte_i & Lead2Mask) == Lead2Pat) begin
        state_o.pending = PendW'(1);
        state_o.partial = CpW'(byte_i[4:0]);
      end else if ((byte_i & Lead3Mask) == Lead3Pat) begin
        state_o.pending = PendW'(2);
        state_o.partial = CpW'(byte_i[3:0]);
      end else if ((byte_i & Lead4Mask) == Lead4Pat) begin
        state_o.pending = PendW'(3);
        state_o.partial = CpW'(byte_i[2:0]);
      end else if (state_i.pending == '0) begin
        // stray continuation or 11111xxx with nothing open: skipped
        state_o = state_i;
      end
    end
    if (eos_i) begin
      state_o = '0;
    end
  end

endmodule

@@ hw/rtl/utf8_stream_decoder_core.sv @@
// UTF-8 stream decoder, one byte per item in, one code point per completed
// sequence out. Depends on u8sd_pkg and u8sd_step.
//
// Rate: one item per cycle sustained unless a result is held by out_stall_i.
// An item is held in the input register, decoded there against the running
// state, and its code point (if any) lands in the output register. The state
// update is a small decode plus a 6-bit shift-or and sets the cycle. Lead
// bytes start sequences of 1 to 4 bytes; invalid leads are skipped; a
// non-continuation byte inside a sequence drops it and starts afresh; the
// end-of-string mark drops any unfinished sequence after its byte is handled.
// No range, overlong or surrogate checks: any 21-bit value passes.
module utf8_stream_decoder_core import u8sd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // input channel
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] in_byte_i,
  input  logic             end_of_string_i,
  // output channel
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [CpW-1:0]   code_point_o
);

  // input register
  logic             in_valid_q, in_valid_d;
  logic [ByteW-1:0] byte_q;
  logic             eos_q;
  // decoder state
  u8sd_state_t      state_q, state_d;
  // result register
  logic             out_valid_q, out_valid_d;
  logic [CpW-1:0]   cp_q;

  u8sd_result_t     res;
  logic             out_free;   // result register can take a new value
  logic             consume;    // item in input register is processed
  logic             load_in;

  assign out_free = !out_valid_q || !out_stall_i;
  assign consume  = in_valid_q && out_free;
  assign load_in  = !in_valid_q || out_free;

  assign in_stall_o   = !load_in;
  assign out_valid_o  = out_valid_q;
  assign code_point_o = cp_q;

  u8sd_step u_step (
    .byte_i   (byte_q),
    .eos_i    (eos_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (load_in) begin
      in_valid_d = in_valid_i;
    end
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = consume && res.emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (consume) begin
        state_q <= state_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (load_in && in_valid_i) begin
      byte_q <= in_byte_i;
      eos_q  <= end_of_string_i;
    end
    if (consume && res.emit) begin
      cp_q <= res.code_point;
    end
  end

endmodule

@@ tb/u8sd_tb_pkg.sv @@
// u8sd_tb_pkg: code point predictor and result scoreboard for the UTF-8 stream decoder.
// Depends on u8sd_pkg for the widths and byte masks.
`timescale 1ns / 1ps
package u8sd_tb_pkg;
  import u8sd_pkg::*;

  typedef enum logic [2:0] {
    KindAscii,
    KindLead2,
    KindLead3,
    KindLead4,
    KindCont,
    KindBad
  } byte_kind_e;

  function automatic byte_kind_e byte_kind(logic [ByteW-1:0] b);
    if (!b[ByteW-1])                       return KindAscii;
    if ((b & ContMask) == ContPat)         return KindCont;
    if ((b & Lead2Mask) == Lead2Pat)       return KindLead2;
    if ((b & Lead3Mask) == Lead3Pat)       return KindLead3;
    if ((b & Lead4Mask) == Lead4Pat)       return KindLead4;
    return KindBad;
  endfunction

  class cp_scoreboard;
    logic [PendW-1:0] cont_left;
    logic [CpW-1:0]   cp_so_far;
    logic [CpW-1:0]   expected_cps[$];
    int unsigned      errors;
    int unsigned      matched;

    function new();
      cont_left = '0;
      cp_so_far = '0;
      errors    = 0;
      matched   = 0;
    endfunction

    // Queues one predicted code point behind those already waiting.
    function void add_expected(logic [CpW-1:0] cp);
      expected_cps = {expected_cps, cp};
    endfunction

    // Applies one accepted item to the predicted state. Returns 1 when the
    // byte was a stray lead that left the decoder untouched.
    function bit note_byte(logic [ByteW-1:0] b, logic eos);
      byte_kind_e kind;
      bit         as_lead;
      bit         was_idle;
      kind     = byte_kind(b);
      as_lead  = 1'b1;
      was_idle = (cont_left == '0);
      if (!was_idle) begin
        if (kind == KindCont) begin
          as_lead   = 1'b0;
          cp_so_far = {cp_so_far[CpW-PayW-1:0], b[PayW-1:0]};
          cont_left = cont_left - 1'b1;
          if (cont_left == '0) begin
            add_expected(cp_so_far);
            cp_so_far = '0;
          end
        end else begin
          cont_left = '0;
          cp_so_far = '0;
        end
      end
      if (as_lead) begin
        case (kind)
          KindAscii: add_expected(CpW'(b));
          KindLead2: begin
            cp_so_far = CpW'(b[4:0]);
            cont_left = PendW'(1);
          end
          KindLead3: begin
            cp_so_far = CpW'(b[3:0]);
            cont_left = PendW'(2);
          end
          KindLead4: begin
            cp_so_far = CpW'(b[2:0]);
            cont_left = PendW'(3);
          end
          default: ;
        endcase
      end
      if (eos) begin
        cont_left = '0;
        cp_so_far = '0;
      end
      return was_idle && (kind == KindCont || kind == KindBad);
    endfunction

    function void check_code_point(logic [CpW-1:0] got);
      logic [CpW-1:0] want;
      if (expected_cps.size() == 0) begin
        $error("code_point: expected none, actual 0x%06h", got);
        errors++;
      end else begin
        want = expected_cps.pop_front();
        if (got !== want) begin
          $error("code_point: expected 0x%06h, actual 0x%06h", want, got);
          errors++;
        end else begin
          matched++;
        end
      end
    endfunction

    function int unsigned outstanding();
      return expected_cps.size();
    endfunction
  endclass

endpackage

@@ tb/tb.sv @@
// tb: self-checking bench for utf8_stream_decoder_core, directed bytes then random strings.
// Depends on u8sd_pkg and u8sd_tb_pkg; drives both channels with random idling.
`timescale 1ns / 1ps
module tb;
  import u8sd_pkg::*;
  import u8sd_tb_pkg::*;

  localparam int unsigned RandItems = 1500;
  localparam int unsigned IdlePct   = 38;
  localparam int unsigned Latency   = 8;   // settle margin beyond the input and result registers

  logic             clk_i           = 1'b0;
  logic             rst_ni          = 1'b0;
  logic             in_valid_i      = 1'b0;
  logic [ByteW-1:0] in_byte_i       = '0;
  logic             end_of_string_i = 1'b0;
  logic             out_stall_i     = 1'b0;
  logic             in_stall_o;
  logic             out_valid_o;
  logic [CpW-1:0]   code_point_o;

  cp_scoreboard sb = new();

  int unsigned idle_pct    = IdlePct;
  int unsigned bytes_used  = 0;    // accepted items that the decoder acted on
  int unsigned bytes_total = 0;
  int unsigned strings     = 0;
  bit          drained     = 1'b0;

  // Directed items, end-of-string mark in bit 8:
  //   smallest and largest ASCII, 2-byte, 3-byte and the top 4-byte value,
  //   stray leads (lone continuation, 0xFF, 0xF8), a sequence broken by an
  //   ASCII byte, a sequence cut short by the end mark, a stray continuation
  //   after that, and an overlong form completed by the marked byte.
  logic [ByteW:0] directed_items [23] = '{
    9'h000, 9'h17F,
    9'h0C2, 9'h0A9, 9'h0DF, 9'h1BF,
    9'h0E2, 9'h082, 9'h0AC,
    9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,
    9'h080, 9'h0FF, 9'h0F8,
    9'h0E2, 9'h041,
    9'h0E2, 9'h182, 9'h0A9,
    9'h0C0, 9'h180
  };

  utf8_stream_decoder_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_byte_i      (in_byte_i),
    .end_of_string_i(end_of_string_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .code_point_o   (code_point_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Result side: values sampled here are the ones held before the edge, so
  // the handshake is judged on what the decoder presented in the last cycle.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_code_point(code_point_o);
    end
    out_stall_i <= ($urandom_range(99) < idle_pct);
  end

  // Offers one item, idling first at random, and holds it until taken.
  // Called at a rising edge; returns at the edge where the item went in.
  task automatic send_byte(logic [ByteW-1:0] b, logic eos);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    in_byte_i       <= b;
    end_of_string_i <= eos;
    do @(posedge clk_i); while (in_stall_o);
    bytes_total++;
    if (eos) strings++;
    if (!sb.note_byte(b, eos)) bytes_used++;
  endtask

  // Sends a sequence of 'len' bytes with random payload bits, of which only
  // the first 'keep' go out; keep < len gives a truncated sequence. The end
  // mark, if asked for, sits on the last byte sent.
  task automatic send_sequence(int unsigned len, int unsigned keep, bit eos_last);
    logic [ByteW-1:0] b;
    for (int unsigned k = 0; k < keep; k++) begin
      if (k == 0) begin
        case (len)
          1:       b = {1'b0, 7'($urandom)};
          2:       b = {3'b110, 5'($urandom)};
          3:       b = {4'b1110, 4'($urandom)};
          default: b = {5'b11110, 3'($urandom)};
        endcase
      end else begin
        b = {2'b10, 6'($urandom)};
      end
      send_byte(b, eos_last && (k == keep - 1));
    end
  endtask

  // Sender holds off until every expected code point is out, then lets the
  // pipe settle.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
  endtask

  initial begin
    int unsigned pick;
    int unsigned len;
    int unsigned wait_cycles;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_items[i]) begin
      send_byte(directed_items[i][ByteW-1:0], directed_items[i][ByteW]);
    end
    drain_results();

    // Mostly well-formed strings with random content; some raw noise and
    // some truncated sequences so the broken and end-of-string paths get hit
    // in every partial state.
    while (bytes_used < RandItems) begin
      idle_pct = (bytes_used >= 600 && bytes_used < 900) ? 0 : IdlePct;
      if (!drained && bytes_used >= 1100) begin
        drain_results();
        drained = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_sequence($urandom_range(4, 1), 0, 1'b0);
        len = $urandom_range(4, 1);
        send_sequence(len, len, ($urandom_range(7) == 0));
      end else if (pick < 85) begin
        send_byte(ByteW'($urandom), ($urandom_range(3) == 0));
      end else begin
        len = $urandom_range(4, 2);
        send_sequence(len, $urandom_range(len - 1, 1), ($urandom_range(3) == 0));
      end
    end
    in_valid_i <= 1'b0;
    idle_pct = IdlePct;

    wait_cycles = 0;
    while (sb.outstanding() != 0 && wait_cycles < 10000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (Latency) @(posedge clk_i);
    if (sb.outstanding() != 0) begin
      $error("code_point: expected %0d more, actual none", sb.outstanding());
      sb.errors++;
    end

    $display("Run: %0d bytes in (%0d acted on), %0d strings ended, %0d code points matched.",
             bytes_total, bytes_used, strings, sb.matched);
    $display("Covered stray leads, broken and truncated sequences, idle-free stretch and a full drain.");
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest plausible run.
  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end

endmodule

@@ utf8_stream_decoder_core.f @@
hw/rtl/u8sd_pkg.sv
hw/rtl/u8sd_step.sv
hw/rtl/utf8_stream_decoder_core.sv
tb/u8sd_tb_pkg.sv
tb/tb.sv
